@@ src/mfd_pkg.sv @@
// Shared types and constants for the MQTT frame delimiter.
// No dependencies; imported by mfd_core, mqtt_frame_delimiter and the testbench.
`timescale 1ns / 1ps

package mfd_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned SizeWidth   = 29;
  localparam int unsigned AccumWidth  = 28;
  localparam int unsigned RoleWidth   = 2;
  localparam int unsigned StatusWidth = 3;

  // Defaults
  localparam int unsigned HeaderMaxBytesDefault = 5;
  localparam logic [SizeWidth-1:0] MaxMessageSizeReset = 29'd1024;

  // Byte roles
  localparam logic [RoleWidth-1:0] ROLE_CONTROL = 2'd0;
  localparam logic [RoleWidth-1:0] ROLE_LENGTH  = 2'd1;
  localparam logic [RoleWidth-1:0] ROLE_BODY    = 2'd2;
  localparam logic [RoleWidth-1:0] ROLE_NONE    = 2'd3;

  // Status codes
  localparam logic [StatusWidth-1:0] STATUS_OK        = 3'd0;
  localparam logic [StatusWidth-1:0] STATUS_ILLEGAL   = 3'd1;
  localparam logic [StatusWidth-1:0] STATUS_TOO_LARGE = 3'd2;
  localparam logic [StatusWidth-1:0] STATUS_DROPPED   = 3'd3;
  localparam logic [StatusWidth-1:0] STATUS_RESTARTED = 3'd4;

  // Input action codes
  localparam logic ACTION_BYTE    = 1'b0;
  localparam logic ACTION_RESTART = 1'b1;

  // One result item
  typedef struct packed {
    logic [7:0]             out_byte;
    logic [RoleWidth-1:0]   byte_role;
    logic                   frame_last;
    logic [StatusWidth-1:0] status;
    logic [SizeWidth-1:0]   frame_total;
  } result_t;

endpackage

@@ src/mfd_core.sv @@
// Frame tracking state and per-byte decode for the MQTT frame delimiter.
// Depends on mfd_pkg; instantiated by mqtt_frame_delimiter.
`timescale 1ns / 1ps

module mfd_core
  import mfd_pkg::*;
#(
  parameter int unsigned HEADER_MAX_BYTES = HeaderMaxBytesDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 action,
  input  logic [7:0]           data_byte,
  input  logic [SizeWidth-1:0] max_message_size,
  output result_t              result
);

  // Length byte counter holds at most HEADER_MAX_BYTES - 1
  localparam int unsigned CountWidth = (HEADER_MAX_BYTES > 2) ? $clog2(HEADER_MAX_BYTES) : 1;

  logic [SizeWidth-1:0]  frame_position, frame_position_next;
  logic                  size_known, size_known_next;
  logic [AccumWidth-1:0] length_accum, length_accum_next;
  logic [CountWidth-1:0] length_byte_count, length_byte_count_next;
  logic [SizeWidth-1:0]  frame_size, frame_size_next;
  logic                  error_latched, error_latched_next;

  logic [2:0]            count_ext;
  logic [2:0]            count_inc;
  logic [AccumWidth-1:0] group_shifted;
  logic [AccumWidth-1:0] accum_new;
  logic [SizeWidth-1:0]  total;
  logic [SizeWidth-1:0]  position_inc;

  // Place the 7-bit group at its position in the remaining length
  always_comb begin
    count_ext = 3'(length_byte_count);
    count_inc = count_ext + 3'd1;
    case (count_ext)
      3'd0:    group_shifted = {21'd0, data_byte[6:0]};
      3'd1:    group_shifted = {14'd0, data_byte[6:0], 7'd0};
      3'd2:    group_shifted = {7'd0, data_byte[6:0], 14'd0};
      3'd3:    group_shifted = {data_byte[6:0], 21'd0};
      default: group_shifted = '0;
    endcase
    accum_new    = length_accum | group_shifted;
    total        = SizeWidth'(count_inc) + SizeWidth'(1) + SizeWidth'(accum_new);
    position_inc = frame_position + SizeWidth'(1);
  end

  // Next state and result for the current item
  always_comb begin
    frame_position_next    = frame_position;
    size_known_next        = size_known;
    length_accum_next      = length_accum;
    length_byte_count_next = length_byte_count;
    frame_size_next        = frame_size;
    error_latched_next     = error_latched;
    result                 = '{out_byte: 8'd0, byte_role: ROLE_NONE, frame_last: 1'b0,
                               status: STATUS_OK, frame_total: '0};

    if (action == ACTION_RESTART) begin
      frame_position_next    = '0;
      size_known_next        = 1'b0;
      length_accum_next      = '0;
      length_byte_count_next = '0;
      frame_size_next        = '0;
      error_latched_next     = 1'b0;
      result.status          = STATUS_RESTARTED;
    end else if (error_latched) begin
      result.status = STATUS_DROPPED;
    end else if (frame_position == '0) begin
      // control byte
      frame_position_next = SizeWidth'(1);
      result.out_byte     = data_byte;
      result.byte_role    = ROLE_CONTROL;
    end else if (!size_known) begin
      // length byte
      length_accum_next      = accum_new;
      length_byte_count_next = CountWidth'(count_inc);
      frame_position_next    = position_inc;
      result.out_byte        = data_byte;
      result.byte_role       = ROLE_LENGTH;
      if (data_byte[7]) begin
        if ((32'(count_inc) + 32'd1) >= 32'(HEADER_MAX_BYTES) || count_inc >= 3'd4) begin
          error_latched_next = 1'b1;
          result.status      = STATUS_ILLEGAL;
        end
      end else if (total > max_message_size) begin
        error_latched_next = 1'b1;
        result.status      = STATUS_TOO_LARGE;
        result.frame_total = total;
      end else begin
        frame_size_next    = total;
        size_known_next    = 1'b1;
        result.frame_total = total;
        // zero remaining length ends the frame here
        if (position_inc >= total) begin
          frame_position_next    = '0;
          size_known_next        = 1'b0;
          length_accum_next      = '0;
          length_byte_count_next = '0;
          frame_size_next        = '0;
          result.frame_last      = 1'b1;
        end
      end
    end else begin
      // body byte
      frame_position_next = position_inc;
      result.out_byte     = data_byte;
      result.byte_role    = ROLE_BODY;
      result.frame_total  = frame_size;
      if (position_inc >= frame_size) begin
        frame_position_next    = '0;
        size_known_next        = 1'b0;
        length_accum_next      = '0;
        length_byte_count_next = '0;
        frame_size_next        = '0;
        result.frame_last      = 1'b1;
      end
    end
  end

  // State registers, updated once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position    <= '0;
      size_known        <= 1'b0;
      length_accum      <= '0;
      length_byte_count <= '0;
      frame_size        <= '0;
      error_latched     <= 1'b0;
    end else if (step) begin
      frame_position    <= frame_position_next;
      size_known        <= size_known_next;
      length_accum      <= length_accum_next;
      length_byte_count <= length_byte_count_next;
      frame_size        <= frame_size_next;
      error_latched     <= error_latched_next;
    end
  end

endmodule

@@ src/mqtt_frame_delimiter.sv @@
// Top level of the MQTT frame delimiter: handshakes, input and result registers.
// Depends on mfd_pkg and mfd_core.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    action, data_byte
//   out      output     out_valid / out_ready  out_byte, byte_role, frame_last,
//                                              status, frame_total
//   config   input      max_message_size_we    max_message_size
//
// One item per cycle sustained while out_ready stays high; an accepted input item
// passes through the input register, then decode into the result register.
// The frame state update is a single step of the decode logic per item.
// Synchronous reset clears the pipeline valids and frame state and sets the
// maximum size to 1024. A stalled result holds both stages; in_ready drops
// only when the input register is full and cannot move on.
`timescale 1ns / 1ps

module mqtt_frame_delimiter
  import mfd_pkg::*;
#(
  parameter int unsigned HEADER_MAX_BYTES = HeaderMaxBytesDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   action,
  input  logic [7:0]             data_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic [RoleWidth-1:0]   byte_role,
  output logic                   frame_last,
  output logic [StatusWidth-1:0] status,
  output logic [SizeWidth-1:0]   frame_total,
  input  logic                   max_message_size_we,
  input  logic [SizeWidth-1:0]   max_message_size
);

  logic                 s1_valid;
  logic                 s1_action;
  logic [7:0]           s1_byte;
  logic                 advance;
  logic [SizeWidth-1:0] max_size;
  result_t              core_result;
  result_t              out_item;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= MaxMessageSizeReset;
    end else if (max_message_size_we) begin
      max_size <= max_message_size;
    end
  end

  // Pipeline control
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_action <= action;
      s1_byte   <= data_byte;
    end
  end

  // Decode and frame state
  mfd_core #(
    .HEADER_MAX_BYTES(HEADER_MAX_BYTES)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .action           (s1_action),
    .data_byte        (s1_byte),
    .max_message_size (max_size),
    .result           (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= core_result;
    end
  end

  assign out_byte    = out_item.out_byte;
  assign byte_role   = out_item.byte_role;
  assign frame_last  = out_item.frame_last;
  assign status      = out_item.status;
  assign frame_total = out_item.frame_total;

  // Checks
  a_last_ok : assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> status == STATUS_OK && frame_total != '0)
    else $error("frame end reported with bad status or zero size");

  a_role_none : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((byte_role == ROLE_NONE) ==
                   (status == STATUS_DROPPED || status == STATUS_RESTARTED)))
    else $error("role none does not match dropped or restart status");

  a_stall_only : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled without a full pipeline");

  a_advance_fills : assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed item did not reach the result register");

endmodule

@@ test/mqtt_frame_delimiter_tb.sv @@
// Self-checking testbench for mqtt_frame_delimiter: byte stream in, one result per byte out.
// An item-level predictor of the framing state checks every result field by field.
// Depends on mfd_pkg and the mqtt_frame_delimiter RTL.
`timescale 1ns / 1ps

module mqtt_frame_delimiter_tb;
  import mfd_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseItems    = 112;
  localparam int unsigned NumPhases     = 8;

  typedef struct {
    logic        act;
    logic [7:0]  byte_val;
    int unsigned gap;
  } stream_item_t;

  // Clock, reset and block ports
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic action = ACTION_BYTE;
  logic [7:0] data_byte = 8'd0;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [SizeWidth-1:0] cfg_size = '0;
  logic in_ready;
  logic out_valid;
  logic [7:0] out_byte;
  logic [RoleWidth-1:0] byte_role;
  logic frame_last;
  logic [StatusWidth-1:0] status;
  logic [SizeWidth-1:0] frame_total;

  // Stimulus and expectation stores
  stream_item_t pending_q[$];
  result_t      expected_q[$];
  int unsigned  bytes_in_flight = 0;
  int unsigned  phase_count = 0;
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  int           send_wait = -1;
  int unsigned  rx_wait = 0;
  logic         in_taken = 1'b0;
  logic         calm = 1'b0;

  // Predictor copy of the framing state and the size limit
  logic [SizeWidth-1:0]  frm_pos = '0;
  logic                  len_known = 1'b0;
  logic [AccumWidth-1:0] rem_len = '0;
  logic [2:0]            len_bytes = '0;
  logic [SizeWidth-1:0]  frm_total = '0;
  logic                  in_error = 1'b0;
  logic [SizeWidth-1:0]  size_limit = MaxMessageSizeReset;

  logic [SizeWidth-1:0] phase_limits [NumPhases] = '{
    29'd300, 29'd2, 29'd1, 29'd0, 29'd268435460, 29'h1FFFFFFF, 29'd64, MaxMessageSizeReset
  };

  always #6 clk = ~clk;

  mqtt_frame_delimiter u_top (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .action              (action),
    .data_byte           (data_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .byte_role           (byte_role),
    .frame_last          (frame_last),
    .status              (status),
    .frame_total         (frame_total),
    .max_message_size_we (cfg_we),
    .max_message_size    (cfg_size)
  );

  // Wait drawn for each item on either side; calm phases run back to back
  function automatic int unsigned draw_wait();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic void clear_frame();
    frm_pos   = '0;
    len_known = 1'b0;
    rem_len   = '0;
    len_bytes = '0;
    frm_total = '0;
  endfunction

  // Advance the framing state by one item and return the result it gives
  function automatic result_t predict_frame_step(logic act, logic [7:0] b);
    result_t     r;
    int unsigned count;
    int unsigned total;
    r.out_byte    = 8'd0;
    r.byte_role   = ROLE_NONE;
    r.frame_last  = 1'b0;
    r.status      = STATUS_OK;
    r.frame_total = '0;
    if (act == ACTION_RESTART) begin
      clear_frame();
      in_error = 1'b0;
      r.status = STATUS_RESTARTED;
    end else if (in_error) begin
      r.status = STATUS_DROPPED;
    end else if (frm_pos == 0) begin
      frm_pos     = SizeWidth'(1);
      r.out_byte  = b;
      r.byte_role = ROLE_CONTROL;
    end else if (!len_known) begin
      r.out_byte  = b;
      r.byte_role = ROLE_LENGTH;
      count = 32'(len_bytes);
      // only the low seven bits of each group count
      if (count < 4) rem_len = rem_len | ({21'd0, b[6:0]} << (7 * count));
      count++;
      len_bytes = count[2:0];
      frm_pos   = frm_pos + 1'b1;
      if (b[7]) begin
        if (count + 1 >= HeaderMaxBytesDefault || count >= 4) begin
          in_error = 1'b1;
          r.status = STATUS_ILLEGAL;
        end
      end else begin
        total = count + 1 + 32'(rem_len);
        r.frame_total = total[SizeWidth-1:0];
        if (total[SizeWidth-1:0] > size_limit) begin
          in_error = 1'b1;
          r.status = STATUS_TOO_LARGE;
        end else begin
          frm_total = total[SizeWidth-1:0];
          len_known = 1'b1;
          if (frm_pos >= frm_total) begin
            clear_frame();
            r.frame_last = 1'b1;
          end
        end
      end
    end else begin
      r.out_byte    = b;
      r.byte_role   = ROLE_BODY;
      r.frame_total = frm_total;
      frm_pos = frm_pos + 1'b1;
      if (frm_pos >= frm_total) begin
        clear_frame();
        r.frame_last = 1'b1;
      end
    end
    return r;
  endfunction

  // Four-state compare so unknown outputs are caught
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Stimulus helpers
  task automatic push_byte(logic act, logic [7:0] b);
    stream_item_t it;
    it.act      = act;
    it.byte_val = b;
    it.gap      = draw_wait();
    pending_q.push_back(it);
    bytes_in_flight++;
    phase_count++;
  endtask

  function automatic int unsigned min_groups(logic [AccumWidth-1:0] rem);
    if (rem[27:21] != 0) return 4;
    if (rem[20:14] != 0) return 3;
    if (rem[13:7] != 0) return 2;
    return 1;
  endfunction

  // Control byte, then the length in groups; continuation flag on all but the last
  task automatic push_header(logic [7:0] ctrl, logic [AccumWidth-1:0] rem, int unsigned groups);
    push_byte(ACTION_BYTE, ctrl);
    for (int i = 0; i < groups; i++)
      push_byte(ACTION_BYTE, {(i < groups - 1) ? 1'b1 : 1'b0, rem[7*i +: 7]});
  endtask

  task automatic push_body(int unsigned n);
    repeat (n) push_byte(ACTION_BYTE, 8'($urandom_range(0, 255)));
  endtask

  task automatic push_restart();
    push_byte(ACTION_RESTART, 8'($urandom_range(0, 255)));
  endtask

  // Mostly whole frames with random content, the rest broken or noisy
  task automatic run_random_phase(int unsigned n_items);
    int unsigned           kind;
    logic [AccumWidth-1:0] rem;
    phase_count = 0;
    while (phase_count < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        if ($urandom_range(0, 4) == 0) push_restart();
        rem = AccumWidth'(($urandom_range(0, 11) == 0) ? $urandom_range(25, 160)
                                                        : $urandom_range(0, 24));
        push_header(8'($urandom_range(0, 255)), rem, $urandom_range(min_groups(rem), 4));
        push_body(32'(rem));
      end else if (kind < 70) begin
        // large declared length, abandoned after a few body bytes
        rem = AccumWidth'($urandom() >> $urandom_range(4, 31));
        push_header(8'($urandom_range(0, 255)), rem, min_groups(rem));
        push_body($urandom_range(0, 4));
        push_restart();
      end else if (kind < 78) begin
        // length field that never ends
        push_byte(ACTION_BYTE, 8'($urandom_range(0, 255)));
        repeat (4) push_byte(ACTION_BYTE, {1'b1, 7'($urandom_range(0, 127))});
        push_body($urandom_range(0, 3));
        push_restart();
      end else if (kind < 86) begin
        // frame cut short
        rem = AccumWidth'($urandom_range(2, 24));
        push_header(8'($urandom_range(0, 255)), rem, min_groups(rem));
        push_body($urandom_range(0, 32'(rem) - 1));
        push_restart();
      end else if (kind < 95) begin
        // line noise
        repeat ($urandom_range(1, 8))
          push_byte(($urandom_range(0, 4) == 0) ? ACTION_RESTART : ACTION_BYTE,
                    8'($urandom_range(0, 255)));
        push_restart();
      end else begin
        push_restart();
      end
    end
  endtask

  // Limit written only once every result is back
  task automatic set_size_limit(logic [SizeWidth-1:0] value);
    do @(negedge clk); while (bytes_in_flight != 0);
    cfg_we   <= 1'b1;
    cfg_size <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    size_limit = value;
    @(posedge clk);
  endtask

  // Driver: sender and receiver both change at the falling edge
  always @(negedge clk) begin : driver
    stream_item_t it;
    logic         drive_valid;
    if (!rst) begin
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      if (!in_valid || in_taken) begin
        in_taken    = 1'b0;
        drive_valid = 1'b0;
        if (pending_q.size() > 0) begin
          if (send_wait < 0) send_wait = pending_q[0].gap;
          if (send_wait > 0) begin
            send_wait--;
          end else begin
            it = pending_q.pop_front();
            action      <= it.act;
            data_byte   <= it.byte_val;
            drive_valid = 1'b1;
            send_wait   = -1;
          end
        end
        in_valid <= drive_valid;
      end
    end
  end

  // Monitor: results checked and items predicted at the rising edge
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected: byte %0d role %0d status %0d",
                 out_byte, byte_role, status);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          bytes_in_flight--;
          check_field("out_byte", 32'(want.out_byte), 32'(out_byte));
          check_field("byte_role", 32'(want.byte_role), 32'(byte_role));
          check_field("frame_last", 32'(want.frame_last), 32'(frame_last));
          check_field("status", 32'(want.status), 32'(status));
          check_field("frame_total", 32'(want.frame_total), 32'(frame_total));
        end
        rx_wait = draw_wait();
      end
      if (in_valid && in_ready) begin
        expected_q.push_back(predict_frame_step(action, data_byte));
        in_taken = 1'b1;
      end
      // watchdog on cycles with no handshake at all
      if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [SizeWidth-1:0] limit;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset limit
    // zero remaining length: the length byte closes the frame
    push_header(8'h30, 28'd0, 1);
    // byte extremes in a short frame
    push_header(8'hFF, 28'd3, 1);
    push_byte(ACTION_BYTE, 8'h00);
    push_byte(ACTION_BYTE, 8'hFF);
    push_byte(ACTION_BYTE, 8'hA5);
    // too many length bytes, then a dropped byte until restart
    push_byte(ACTION_BYTE, 8'h82);
    repeat (4) push_byte(ACTION_BYTE, 8'h80);
    push_byte(ACTION_BYTE, 8'h55);
    push_byte(ACTION_RESTART, 8'hFF);
    // one over the limit
    push_header(8'h10, 28'd1022, 2);
    push_byte(ACTION_RESTART, 8'h00);
    // exactly at the limit, abandoned part way
    push_header(8'h20, 28'd1021, 2);
    push_byte(ACTION_BYTE, 8'h01);
    push_byte(ACTION_BYTE, 8'hFE);
    push_byte(ACTION_RESTART, 8'h00);
    // restart with no frame in progress
    push_byte(ACTION_RESTART, 8'h00);

    // Random phases, each under its own limit
    for (int p = 0; p < NumPhases; p++) begin
      limit = (p == 6) ? SizeWidth'($urandom_range(20, 200)) : phase_limits[p];
      set_size_limit(limit);
      calm = ($urandom_range(0, 3) == 0);
      if (limit >= 29'd268435460) begin
        // largest length the field can carry
        push_header(8'h3C, 28'hFFFFFFF, 4);
        push_body(3);
        push_restart();
      end
      run_random_phase(PhaseItems);
    end

    do @(negedge clk); while (bytes_in_flight != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
